FILE: hdl/asu_pkg.sv
// Shared types and constants of the advection stencil update block.
`timescale 1ns / 1ps
`default_nettype none
package asu_pkg;

    localparam int VEL_W   = 32;
    localparam int POS_W   = 10;
    localparam int SIZE_W  = 11;
    localparam int CFG_AW  = 2;
    localparam int DT_FRAC = 24;
    localparam int MAG_W   = 62;

    localparam logic [CFG_AW-1:0] CFG_TIME_STEP   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_GRID_WIDTH  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_GRID_HEIGHT = 2'd2;

    typedef struct packed {
        logic signed [VEL_W-1:0] u_in;
        logic signed [VEL_W-1:0] v_in;
        logic [VEL_W-1:0]        inv_two_dx;
        logic [VEL_W-1:0]        inv_two_dy;
        logic                    is_flush;
    } t_in_item;

    typedef struct packed {
        logic signed [VEL_W-1:0] u_out;
        logic signed [VEL_W-1:0] v_out;
        logic [POS_W-1:0]        column;
        logic [POS_W-1:0]        row;
        logic                    is_edge;
        logic                    saturated;
        logic                    last_of_frame;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic [VEL_W-1:0]   b;
        logic               neg_b;
        logic               use_dt;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic               sat;
        logic signed [63:0] res;
    } t_mul_rsp;

endpackage
`default_nettype wire

FILE: hdl/advection_stencil_update_core.sv
// Top level of the streaming central-difference advection stencil.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in  (asu_pkg::t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out (asu_pkg::t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// An item that emits no point leaves the block idle and ready for the next item.
// An emitted point first runs a restoring division for its row and column, then
// five reads of the history RAM; an edge point then goes straight to the finish
// state, and an interior point runs ten operations through the multiply pipeline.
// Reset is synchronous and active low; the history RAM is not cleared.
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none
module advection_stencil_update_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire asu_pkg::t_in_item             i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output asu_pkg::t_out_item                 o_out,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [asu_pkg::CFG_AW-1:0]    i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int QW    = $clog2(MAX_HEIGHT);
    localparam int DCW   = $clog2(QW);
    localparam int KW    = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
    localparam int DEPTH = 2 * MAX_WIDTH + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = AW + 1;
    localparam int DVW   = CW + QW;
    localparam int WW    = 4 * asu_pkg::VEL_W;

    localparam logic [2:0] OP_GX = 3'd0;
    localparam logic [2:0] OP_GY = 3'd1;
    localparam logic [2:0] OP_TX = 3'd2;
    localparam logic [2:0] OP_TY = 3'd3;
    localparam logic [2:0] OP_DT = 3'd4;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_READ = 6'b000100,
        S_MUL  = 6'b001000,
        S_WAIT = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state;
    logic [31:0] r_time_step;
    logic [asu_pkg::SIZE_W-1:0] r_grid_width, r_grid_height;
    logic [KW-1:0] r_k;
    logic [AW-1:0] r_ptr, r_cptr;
    logic [DVW-1:0] r_rem, r_dsh;
    logic [QW-1:0] r_q;
    logic [DCW-1:0] r_div_cnt;
    logic [2:0] r_rd_cnt, r_op;
    logic r_comp, r_last, r_edge, r_sat, r_out_valid;
    logic [WW-1:0] r_wc;
    logic [63:0] r_wl, r_wr, r_wu, r_wd;
    logic signed [63:0] r_gx, r_gy, r_tx, r_ty;
    logic signed [31:0] r_nu, r_nv;
    asu_pkg::t_out_item r_out;

    logic [CW-1:0] w_c;
    logic [HW-1:0] h_c;
    logic [KW-1:0] total, w1, p;
    logic emit, k_end, in_acc, ignore, store_data, we, div_bit, edge_pt;
    logic fin_go;
    logic [WW-1:0] wdata, rdata;
    logic [AW-1:0] raddr;
    logic [BW-1:0] back;
    logic signed [31:0] uc, vc, old, lft, rgt, upv, dnv;
    logic signed [63:0] diff;
    logic clip;
    logic signed [31:0] clipped;
    asu_pkg::t_mul_req mul_req;
    asu_pkg::t_mul_rsp mul_rsp;

    always_comb begin
        if (r_grid_width < 11'd3) begin
            w_c = CW'(3);
        end else if (int'(r_grid_width) > MAX_WIDTH) begin
            w_c = CW'(MAX_WIDTH);
        end else begin
            w_c = CW'(r_grid_width);
        end
        if (r_grid_height < 11'd3) begin
            h_c = HW'(3);
        end else if (int'(r_grid_height) > MAX_HEIGHT) begin
            h_c = HW'(MAX_HEIGHT);
        end else begin
            h_c = HW'(r_grid_height);
        end
    end

    assign total      = KW'(w_c) * KW'(h_c);
    assign w1         = KW'(w_c) + KW'(1);
    assign p          = r_k - w1;
    assign emit       = (r_k >= w1) && (p < total);
    assign k_end      = r_k >= total + KW'(w_c);
    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc     = i_in_valid && o_in_ready;
    assign ignore     = (r_k == '0) && i_in.is_flush;
    assign store_data = (r_k < total) && !i_in.is_flush;
    assign we         = in_acc && !ignore;
    assign wdata      = store_data ? {i_in.u_in, i_in.v_in, i_in.inv_two_dx, i_in.inv_two_dy}
                                   : '0;
    assign div_bit    = r_rem >= r_dsh;
    assign edge_pt    = (r_q == '0) || (r_rem == '0)
                     || (DVW'(r_q) == DVW'(h_c) - DVW'(1))
                     || (r_rem == DVW'(w_c) - DVW'(1));
    assign fin_go     = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        unique case (r_rd_cnt)
            3'd0:    back = BW'(w_c) + BW'(1);
            3'd1:    back = BW'(w_c) + BW'(2);
            3'd2:    back = BW'(w_c);
            3'd3:    back = BW'(w_c) + BW'(w_c) + BW'(1);
            default: back = BW'(1);
        endcase
        if ({1'b0, r_cptr} >= back) begin
            raddr = AW'({1'b0, r_cptr} - back);
        end else begin
            raddr = AW'({1'b0, r_cptr} + BW'(DEPTH) - back);
        end
    end

    asu_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_ptr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        uc  = r_wc[127:96];
        vc  = r_wc[95:64];
        old = r_comp ? vc : uc;
        lft = r_comp ? r_wl[31:0] : r_wl[63:32];
        rgt = r_comp ? r_wr[31:0] : r_wr[63:32];
        upv = r_comp ? r_wu[31:0] : r_wu[63:32];
        dnv = r_comp ? r_wd[31:0] : r_wd[63:32];
        mul_req.start  = (r_state == S_MUL);
        mul_req.neg_b  = 1'b0;
        mul_req.use_dt = 1'b0;
        unique case (r_op)
            OP_GX: begin
                mul_req.a = 64'(rgt) - 64'(lft);
                mul_req.b = r_wc[63:32];
            end
            OP_GY: begin
                mul_req.a = 64'(dnv) - 64'(upv);
                mul_req.b = r_wc[31:0];
            end
            OP_TX: begin
                mul_req.a     = r_gx;
                mul_req.b     = uc[31] ? 32'(-uc) : uc;
                mul_req.neg_b = uc[31];
            end
            OP_TY: begin
                mul_req.a     = r_gy;
                mul_req.b     = vc[31] ? 32'(-vc) : vc;
                mul_req.neg_b = vc[31];
            end
            default: begin
                mul_req.a      = r_tx + r_ty;
                mul_req.b      = r_time_step;
                mul_req.use_dt = 1'b1;
            end
        endcase
        diff = 64'(old) - mul_rsp.res;
        clip = 1'b1;
        if (diff > 64'sd2147483647) begin
            clipped = 32'sh7FFFFFFF;
        end else if (diff < -64'sd2147483648) begin
            clipped = 32'sh80000000;
        end else begin
            clipped = diff[31:0];
            clip    = 1'b0;
        end
    end

    asu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step   <= '0;
            r_grid_width  <= 11'd1024;
            r_grid_height <= 11'd1024;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                asu_pkg::CFG_TIME_STEP:   r_time_step   <= i_cfg_data;
                asu_pkg::CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[asu_pkg::SIZE_W-1:0];
                asu_pkg::CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[asu_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (we) begin
                        r_k    <= k_end ? '0 : r_k + KW'(1);
                        r_ptr  <= (k_end || r_ptr == AW'(DEPTH - 1)) ? '0 : r_ptr + AW'(1);
                        r_cptr <= r_ptr;
                        if (emit) begin
                            r_rem     <= DVW'(p);
                            r_dsh     <= DVW'(w_c) << (QW - 1);
                            r_q       <= '0;
                            r_div_cnt <= '0;
                            r_last    <= (p == total - KW'(1));
                            r_sat     <= 1'b0;
                            r_state   <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_bit) begin
                        r_rem <= r_rem - r_dsh;
                    end
                    r_q       <= {r_q[QW-2:0], div_bit};
                    r_dsh     <= r_dsh >> 1;
                    r_div_cnt <= r_div_cnt + DCW'(1);
                    if (r_div_cnt == DCW'(QW - 1)) begin
                        r_rd_cnt <= '0;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_rd_cnt <= r_rd_cnt + 3'd1;
                    unique case (r_rd_cnt)
                        3'd1:    r_wc <= rdata;
                        3'd2:    r_wl <= rdata[127:64];
                        3'd3:    r_wr <= rdata[127:64];
                        3'd4:    r_wu <= rdata[127:64];
                        3'd5:    r_wd <= rdata[127:64];
                        default: ;
                    endcase
                    if (r_rd_cnt == 3'd5) begin
                        r_edge  <= edge_pt;
                        r_op    <= OP_GX;
                        r_comp  <= 1'b0;
                        r_state <= edge_pt ? S_FIN : S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (mul_rsp.done) begin
                        r_sat <= r_sat | mul_rsp.sat | ((r_op == OP_DT) && clip);
                        unique case (r_op)
                            OP_GX:   r_gx <= mul_rsp.res;
                            OP_GY:   r_gy <= mul_rsp.res;
                            OP_TX:   r_tx <= mul_rsp.res;
                            OP_TY:   r_ty <= mul_rsp.res;
                            default: begin
                                if (r_comp) begin
                                    r_nv <= clipped;
                                end else begin
                                    r_nu <= clipped;
                                end
                            end
                        endcase
                        if (r_op != OP_DT) begin
                            r_op    <= r_op + 3'd1;
                            r_state <= S_MUL;
                        end else if (!r_comp) begin
                            r_comp  <= 1'b1;
                            r_op    <= OP_GX;
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_out.u_out         <= r_edge ? uc : r_nu;
                        r_out.v_out         <= r_edge ? vc : r_nv;
                        r_out.column        <= asu_pkg::POS_W'(r_rem);
                        r_out.row           <= asu_pkg::POS_W'(r_q);
                        r_out.is_edge       <= r_edge;
                        r_out.saturated     <= r_sat;
                        r_out.last_of_frame <= r_last;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> r_state == S_WAIT)
        else $error("multiply result arrived outside the wait state");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_FIN)
        else $error("output became valid without a finished point");

    a_read_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> r_rd_cnt <= 3'd5)
        else $error("history read sequence overran");
endmodule
`default_nettype wire

FILE: hdl/asu_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module asu_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 2050
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/asu_mul.sv
// Pipelined signed-by-unsigned multiply with truncating shift and magnitude saturation.
`timescale 1ns / 1ps
`default_nettype none
module asu_mul #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire asu_pkg::t_mul_req i_req,
    output asu_pkg::t_mul_rsp      o_rsp
);
    logic [4:0]  r_vld;
    logic [62:0] r_m;
    logic [31:0] r_b;
    logic        r_neg0, r_neg1, r_neg2, r_neg3;
    logic        r_dt0, r_dt1, r_dt2;
    logic [63:0] r_pl, r_pl2;
    logic [62:0] r_ph;
    logic [94:0] r_sh;
    logic [62:0] r_m1;
    logic [31:0] r_b1;
    logic [94:0] prod;
    logic [63:0] mag;
    logic        sat;
    logic        r_sat;
    logic signed [63:0] r_res;

    always_comb begin
        prod = 95'(r_pl2) + (95'(r_ph) << 32);
        sat  = |r_sh[94:asu_pkg::MAG_W];
        mag  = sat ? {2'b00, {asu_pkg::MAG_W{1'b1}}} : {2'b00, r_sh[asu_pkg::MAG_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_req.start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_m    <= i_req.a[63] ? 63'(-i_req.a) : i_req.a[62:0];
        r_b    <= i_req.b;
        r_neg0 <= i_req.a[63] ^ i_req.neg_b;
        r_dt0  <= i_req.use_dt;

        r_pl   <= 64'(r_m[31:0]) * 64'(r_b);
        r_m1   <= r_m;
        r_b1   <= r_b;
        r_neg1 <= r_neg0;
        r_dt1  <= r_dt0;

        r_ph   <= 63'(r_m1[62:32]) * 63'(r_b1);
        r_pl2  <= r_pl;
        r_neg2 <= r_neg1;
        r_dt2  <= r_dt1;

        r_sh   <= r_dt2 ? (prod >> asu_pkg::DT_FRAC) : (prod >> FRAC_BITS);
        r_neg3 <= r_neg2;

        r_res  <= r_neg3 ? -$signed(mag) : $signed(mag);
        r_sat  <= sat;
    end

    assign o_rsp.done = r_vld[4];
    assign o_rsp.sat  = r_sat;
    assign o_rsp.res  = r_res;
endmodule
`default_nettype wire
